// ===== rtl/tcm_pkg.sv =====
// Shared widths, stage map and register codes of the two-axis curve mixer.
package tcm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRACTION_BITS  = 16;

  localparam int NUM_IN_FIELDS  = 6;
  localparam int IN_DATA_BITS   = ((NUM_IN_FIELDS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_VALUE_BITS = 19;
  localparam int OUT_DATA_BITS  = ((OUT_VALUE_BITS + 7) / 8) * 8;
  localparam int FLAG_BITS      = 2;

  localparam int PT_BITS        = 8;
  localparam int NUM_PTS        = 5;
  localparam int CURVE_PT_BITS  = PT_BITS * NUM_PTS;
  localparam int CFG_DATA_BITS  = CURVE_PT_BITS;
  localparam int CFG_INDEX_BITS = 3;

  // Span differences after sign folding.
  localparam int DIFF_BITS      = SAMPLE_BITS + 1;
  // Interpolation accumulator: |p0 * 2^F + (p1 - p0) * t| < 383 * 2^F.
  localparam int ACC_BITS       = FRACTION_BITS + 10;
  localparam int MAG_BITS       = ACC_BITS - 1;
  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  localparam int DIV100_SHIFT   = MAG_BITS + 7;
  localparam int RECIP_BITS     = MAG_BITS + 1;
  localparam longint unsigned DIV100_RECIP_L =
    ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;
  localparam logic [RECIP_BITS-1:0] DIV100_RECIP = RECIP_BITS'(DIV100_RECIP_L);
  localparam int PROD_BITS      = MAG_BITS + RECIP_BITS;
  localparam int QUO100_BITS    = PROD_BITS - DIV100_SHIFT;
  // Curve output: |b| < 1.28 * 2^F.
  localparam int CURVE_BITS     = FRACTION_BITS + 2;

  localparam int MIX_BITS = (FRACTION_BITS + 4 > OUT_VALUE_BITS + 1) ?
                            FRACTION_BITS + 4 : OUT_VALUE_BITS + 1;
  localparam logic signed [MIX_BITS-1:0] OUT_MAX =
    MIX_BITS'((longint'(1) << (OUT_VALUE_BITS - 1)) - 1);
  localparam logic signed [MIX_BITS-1:0] OUT_MIN =
    MIX_BITS'(-(longint'(1) << (OUT_VALUE_BITS - 1)));
  localparam logic [2*CURVE_BITS-1:0] PROD_BIAS =
    (2*CURVE_BITS)'((longint'(1) << FRACTION_BITS) - 1);

  // Pipeline stage map.
  localparam int ST_DIFF     = 0;
  localparam int ST_LOAD     = 1;
  localparam int ST_INTERP   = ST_LOAD + FRACTION_BITS + 1;
  localparam int ST_SCALE    = ST_INTERP + 1;
  localparam int ST_CURVE    = ST_SCALE + 1;
  localparam int ST_MIX      = ST_CURVE + 1;
  localparam int PIPE_STAGES = ST_MIX + 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIRST_VALID   = 3'd0,
    CFG_SECOND_VALID  = 3'd1,
    CFG_MIX_MODE      = 3'd2,
    CFG_FIRST_POINTS  = 3'd3,
    CFG_SECOND_POINTS = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MIX_FIRST = 2'd0,
    MIX_ADD   = 2'd1,
    MIX_MUL   = 2'd2
  } mix_mode_t;

endpackage

// ===== rtl/tcm_axis.sv =====
// One axis lane: span normalization, pipelined divider and curve interpolation.
module tcm_axis (
  input  logic                                      clk,
  input  logic                                      advance,
  input  logic signed [tcm_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic signed [tcm_pkg::SAMPLE_BITS-1:0]    span_lo,
  input  logic signed [tcm_pkg::SAMPLE_BITS-1:0]    span_hi,
  input  logic        [tcm_pkg::CURVE_PT_BITS-1:0]  curve_points,
  output logic signed [tcm_pkg::CURVE_BITS-1:0]     curve_value,
  output logic                                      range_clamped
);
  import tcm_pkg::*;

  // Difference stage.
  logic signed [DIFF_BITS-1:0] num_raw, den_raw;
  logic signed [DIFF_BITS-1:0] num_r, den_r;

  assign num_raw = DIFF_BITS'(sample) - DIFF_BITS'(span_lo);
  assign den_raw = DIFF_BITS'(span_hi) - DIFF_BITS'(span_lo);

  always_ff @(posedge clk) begin
    if (advance) begin
      if (den_raw < 0) begin
        num_r <= -num_raw;
        den_r <= -den_raw;
      end else begin
        num_r <= num_raw;
        den_r <= den_raw;
      end
    end
  end

  // Divider state, one restoring step per stage.
  logic [SAMPLE_BITS-1:0]   rem_r   [0:FRACTION_BITS-1];
  logic [SAMPLE_BITS-1:0]   dv_r    [0:FRACTION_BITS-1];
  logic [FRACTION_BITS-1:0] quo_r   [0:FRACTION_BITS];
  logic                     full_r  [0:FRACTION_BITS];
  logic                     clamp_r [0:FRACTION_BITS];

  // Classification: a zero span or a negative offset gives zero, an offset at
  // or past the span gives exactly one; only the inner case really divides.
  logic span_zero, below, at_top, past_top, do_div;

  always_comb begin
    span_zero = (den_r == '0);
    below     = !span_zero && (num_r < 0);
    at_top    = !span_zero && !below && (num_r >= den_r);
    past_top  = !span_zero && !below && (num_r > den_r);
    do_div    = !span_zero && !below && !at_top;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_r[0]   <= do_div ? num_r[SAMPLE_BITS-1:0] : '0;
      dv_r[0]    <= do_div ? den_r[SAMPLE_BITS-1:0] : SAMPLE_BITS'(1);
      quo_r[0]   <= '0;
      full_r[0]  <= at_top;
      clamp_r[0] <= below || past_top;
    end
  end

  for (genvar gk = 0; gk < FRACTION_BITS; gk++) begin : g_div_step
    logic [SAMPLE_BITS:0] trial;
    logic                 fits;

    assign trial = {rem_r[gk], 1'b0};
    assign fits  = (trial >= {1'b0, dv_r[gk]});

    always_ff @(posedge clk) begin
      if (advance) begin
        quo_r[gk+1]   <= {quo_r[gk][FRACTION_BITS-2:0], fits};
        full_r[gk+1]  <= full_r[gk];
        clamp_r[gk+1] <= clamp_r[gk];
      end
    end

    if (gk < FRACTION_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (advance) begin
          rem_r[gk+1] <= fits ? SAMPLE_BITS'(trial - {1'b0, dv_r[gk]}) :
                                trial[SAMPLE_BITS-1:0];
          dv_r[gk+1]  <= dv_r[gk];
        end
      end
    end
  end

  // Interpolation stage.
  logic [1:0]                               seg;
  logic [2:0]                               seg_hi;
  logic [FRACTION_BITS:0]                   pos;
  logic signed [PT_BITS-1:0]                p0, p1;
  logic signed [PT_BITS:0]                  pdiff;
  logic signed [FRACTION_BITS+1:0]          pos_s;
  logic signed [PT_BITS+FRACTION_BITS-1:0]  base;
  logic signed [FRACTION_BITS+10:0]         term;
  logic signed [ACC_BITS-1:0]               acc_r;
  logic                                     clamp_i_r;

  always_comb begin
    if (full_r[FRACTION_BITS]) begin
      seg = 2'd3;
      pos = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
    end else begin
      seg = quo_r[FRACTION_BITS][FRACTION_BITS-1:FRACTION_BITS-2];
      pos = {1'b0, quo_r[FRACTION_BITS][FRACTION_BITS-3:0], 2'b00};
    end
    seg_hi = 3'(seg) + 3'd1;
    p0     = curve_points[{seg, 3'b000} +: PT_BITS];
    p1     = curve_points[{seg_hi, 3'b000} +: PT_BITS];
    pdiff  = (PT_BITS + 1)'(p1) - (PT_BITS + 1)'(p0);
    pos_s  = {1'b0, pos};
    base   = {p0, FRACTION_BITS'(0)};
    term   = pdiff * pos_s;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      acc_r     <= ACC_BITS'(term + (FRACTION_BITS + 11)'(base));
      clamp_i_r <= clamp_r[FRACTION_BITS];
    end
  end

  // Scale stage: magnitude times the reciprocal of 100.
  logic [ACC_BITS-1:0]  acc_abs;
  logic [PROD_BITS-1:0] scaled_r;
  logic                 neg_r;
  logic                 clamp_s_r;

  assign acc_abs = (acc_r < 0) ? ACC_BITS'(-acc_r) : ACC_BITS'(acc_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      scaled_r  <= acc_abs[MAG_BITS-1:0] * DIV100_RECIP;
      neg_r     <= (acc_r < 0);
      clamp_s_r <= clamp_i_r;
    end
  end

  // Curve stage: shift out the reciprocal scale and restore the sign, which
  // gives truncation toward zero.
  logic signed [QUO100_BITS:0]   quo100;
  logic signed [QUO100_BITS:0]   quo100_sgn;
  logic signed [CURVE_BITS-1:0]  curve_r;
  logic                          clamp_c_r;

  assign quo100     = {1'b0, scaled_r[PROD_BITS-1:DIV100_SHIFT]};
  assign quo100_sgn = neg_r ? -quo100 : quo100;

  always_ff @(posedge clk) begin
    if (advance) begin
      curve_r   <= CURVE_BITS'(quo100_sgn);
      clamp_c_r <= clamp_s_r;
    end
  end

  assign curve_value   = curve_r;
  assign range_clamped = clamp_c_r;

endmodule

// ===== rtl/two_axis_curve_mixer.sv =====
// Top level of the two-axis curve mixer: stream ports, configuration and mixing.
//
// Each input transaction carries two axis samples with their spans. Both axes
// are normalized to a fraction of their span, shaped by a five-point percent
// curve and combined into one signed result with 16 fraction bits; the output
// transaction also reports which axes had to be clamped into their span.
// Configuration (axis enables, mix mode, curve points) is to be written through the
// cfg_ port only while no transaction is in flight; the block does not enforce this.
//
// Throughput is one transaction per clock while the pipeline is not frozen by a
// full skid register. Each axis runs a 16-step restoring divider, one quotient
// bit per pipeline stage.
//
// When the receiver holds out_tready low, the output register keeps its
// transaction and one more result lands in a skid register; only then does
// in_tready drop and the whole pipeline freeze, so nothing is lost or repeated.
// in_tready comes straight from a flop. Reset clears all valid flags and the
// configuration registers: both axes disabled, mix mode "first value", curves
// flat at zero. Reset is synchronous and active low.
module two_axis_curve_mixer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // first_sample, first_min, first_max, second_sample, second_min, second_max
  input  logic [tcm_pkg::IN_DATA_BITS-1:0]      in_tdata,
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // mixed_value, zero padding
  output logic [tcm_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  // range_clamped
  output logic [tcm_pkg::FLAG_BITS-1:0]         out_tuser,
  // Configuration write port.
  input  logic                                  cfg_wr_en,
  input  logic [tcm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tcm_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import tcm_pkg::*;

  typedef enum logic [1:0] {
    SRC_PASS,
    SRC_SUM,
    SRC_PROD
  } src_t;

  // Configuration registers.
  logic                     first_valid_r;
  logic                     second_valid_r;
  logic [1:0]               mix_mode_r;
  logic [CURVE_PT_BITS-1:0] first_points_r;
  logic [CURVE_PT_BITS-1:0] second_points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_valid_r   <= 1'b0;
      second_valid_r  <= 1'b0;
      mix_mode_r      <= MIX_FIRST;
      first_points_r  <= '0;
      second_points_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_VALID:   first_valid_r   <= cfg_wdata[0];
        CFG_SECOND_VALID:  second_valid_r  <= cfg_wdata[0];
        CFG_MIX_MODE:      mix_mode_r      <= cfg_wdata[1:0];
        CFG_FIRST_POINTS:  first_points_r  <= cfg_wdata[CURVE_PT_BITS-1:0];
        CFG_SECOND_POINTS: second_points_r <= cfg_wdata[CURVE_PT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; it stops only when the skid register
  // is occupied, which is a registered condition.
  logic                   advance;
  logic [PIPE_STAGES-1:0] v_r;
  logic                   skid_v_r;

  assign advance   = !skid_v_r;
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[PIPE_STAGES-2:0], in_tvalid};
    end
  end

  // Field unpacking, first field in the lowest bits.
  logic signed [SAMPLE_BITS-1:0] first_sample, first_min, first_max;
  logic signed [SAMPLE_BITS-1:0] second_sample, second_min, second_max;

  assign first_sample  = in_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign first_min     = in_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign first_max     = in_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign second_sample = in_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
  assign second_min    = in_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];
  assign second_max    = in_tdata[5*SAMPLE_BITS +: SAMPLE_BITS];

  logic signed [CURVE_BITS-1:0] first_curve, second_curve;
  logic                         first_clamped, second_clamped;

  tcm_axis u_first_axis (
    .clk           (clk),
    .advance       (advance),
    .sample        (first_sample),
    .span_lo       (first_min),
    .span_hi       (first_max),
    .curve_points  (first_points_r),
    .curve_value   (first_curve),
    .range_clamped (first_clamped)
  );

  tcm_axis u_second_axis (
    .clk           (clk),
    .advance       (advance),
    .sample        (second_sample),
    .span_lo       (second_min),
    .span_hi       (second_max),
    .curve_points  (second_points_r),
    .curve_value   (second_curve),
    .range_clamped (second_clamped)
  );

  // Mix stage: choose the combination and form the sum and the product.
  src_t                           src_nxt, src_r;
  logic signed [CURVE_BITS-1:0]   pass_nxt, pass_r;
  logic [FLAG_BITS-1:0]           flags_nxt, flags_r;
  logic signed [CURVE_BITS:0]     sum_r;
  logic signed [2*CURVE_BITS-1:0] prod_r;

  always_comb begin
    src_nxt   = SRC_PASS;
    pass_nxt  = first_curve;
    flags_nxt = '0;
    priority if (!first_valid_r && !second_valid_r) begin
      pass_nxt = '0;
    end else if (!first_valid_r) begin
      pass_nxt  = second_curve;
      flags_nxt = {second_clamped, 1'b0};
    end else if (!second_valid_r) begin
      flags_nxt = {1'b0, first_clamped};
    end else begin
      flags_nxt = {second_clamped, first_clamped};
      if (mix_mode_r == MIX_ADD) begin
        src_nxt = SRC_SUM;
      end else if (mix_mode_r == MIX_MUL) begin
        src_nxt = SRC_PROD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      src_r   <= src_nxt;
      pass_r  <= pass_nxt;
      flags_r <= flags_nxt;
      sum_r   <= (CURVE_BITS + 1)'(first_curve) + (CURVE_BITS + 1)'(second_curve);
      prod_r  <= first_curve * second_curve;
    end
  end

  // Final arithmetic: the product is scaled down with truncation toward zero,
  // then the chosen value is saturated to the output width.
  logic signed [2*CURVE_BITS-1:0] prod_adj;
  logic signed [MIX_BITS-1:0]     mix_wide;
  logic signed [MIX_BITS-1:0]     mix_sat;
  logic [OUT_VALUE_BITS-1:0]      result_nxt;

  always_comb begin
    prod_adj = prod_r[2*CURVE_BITS-1] ? prod_r + $signed(PROD_BIAS) : prod_r;
    unique case (src_r)
      SRC_SUM:  mix_wide = MIX_BITS'(sum_r);
      SRC_PROD: mix_wide = MIX_BITS'(prod_adj >>> FRACTION_BITS);
      default:  mix_wide = MIX_BITS'(pass_r);
    endcase
    priority if (mix_wide > OUT_MAX) begin
      mix_sat = OUT_MAX;
    end else if (mix_wide < OUT_MIN) begin
      mix_sat = OUT_MIN;
    end else begin
      mix_sat = mix_wide;
    end
    result_nxt = mix_sat[OUT_VALUE_BITS-1:0];
  end

  // Output register plus one skid entry.
  logic                      take;
  logic                      out_free;
  logic                      out_v_r;
  logic [OUT_VALUE_BITS-1:0] out_val_r, skid_val_r;
  logic [FLAG_BITS-1:0]      out_flags_r, skid_flags_r;

  assign take     = advance && v_r[ST_MIX];
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= take;
      end
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_val_r   <= skid_val_r;
        out_flags_r <= skid_flags_r;
      end else begin
        out_val_r   <= result_nxt;
        out_flags_r <= flags_r;
      end
    end
    if (!out_free && take) begin
      skid_val_r   <= result_nxt;
      skid_flags_r <= flags_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_BITS'(out_val_r);
  assign out_tuser  = out_flags_r;

endmodule
